// ===== hw/rtl/srtf_preemptive_scheduler_top_macros.svh =====
// Assertion macros for the shortest-remaining-time-first scheduler.
// Included by the top level; the checks compile away when SYNTHESIS is defined.
`ifndef SRTF_PREEMPTIVE_SCHEDULER_TOP_MACROS_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define SRTF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("srtf scheduler assertion failed");

// The condition must never be true outside reset.
`define SRTF_ASSERT_NEVER(label, cond) \
  `SRTF_ASSERT(label, !(cond))

`else

`define SRTF_ASSERT(label, prop)
`define SRTF_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== hw/rtl/srtf_pkg.sv =====
// Package for the shortest-remaining-time-first scheduler.
// Holds item and result types, codes and widths; used by every RTL file.
package srtf_pkg;

  localparam int MAX_PROCS_DEF = 32;
  localparam int TIME_W        = 16;
  localparam int SUM_W         = 22;
  localparam int PIDX_W        = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_RAN    = 2'd2,
    ST_IDLE   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECR,
    S_TIME,
    S_TAT,
    S_WAIT,
    S_SUMT,
    S_SUMW,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e               operation;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [PIDX_W-1:0] process_index;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              all_done;
    logic [TIME_W-1:0] current_time;
  } result_t;

  // Write strobes of the process table.
  typedef struct packed {
    logic load;  // write arrival, burst and remaining of a new process
    logic dec;   // write back the remaining time only
  } mem_wr_t;

endpackage

// ===== hw/rtl/srtf_alu.sv =====
// Shared add/subtract unit of the scheduler.
// Depends on srtf_pkg for the operand width.
module srtf_alu import srtf_pkg::*; (
  input  logic [SUM_W-1:0] a_i,
  input  logic [SUM_W-1:0] b_i,
  input  logic             sub_i,
  output logic [SUM_W-1:0] res_o,
  output logic             carry_o
);

  logic [SUM_W-1:0] b_eff;

  // On subtract the carry out is set when a is not below b.
  assign b_eff = sub_i ? ~b_i : b_i;
  assign {carry_o, res_o} = {1'b0, a_i} + {1'b0, b_eff} + {{SUM_W{1'b0}}, sub_i};

endmodule

// ===== hw/rtl/srtf_mem.sv =====
// Process table: arrival, burst and remaining time of each slot.
// One write and one registered read per cycle; depends on srtf_pkg.
module srtf_mem import srtf_pkg::*; #(
  parameter int DEPTH = MAX_PROCS_DEF,
  parameter int AW    = 5
) (
  input  logic              clk_i,
  input  mem_wr_t           wr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [TIME_W-1:0] wr_arrival_i,
  input  logic [TIME_W-1:0] wr_burst_i,
  input  logic [TIME_W-1:0] wr_remaining_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [TIME_W-1:0] rd_arrival_o,
  output logic [TIME_W-1:0] rd_burst_o,
  output logic [TIME_W-1:0] rd_remaining_o
);

  logic [TIME_W-1:0] arrival_mem   [DEPTH];
  logic [TIME_W-1:0] burst_mem     [DEPTH];
  logic [TIME_W-1:0] remaining_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.load) begin
      arrival_mem[wr_addr_i] <= wr_arrival_i;
      burst_mem[wr_addr_i]   <= wr_burst_i;
    end
    if (wr_i.load || wr_i.dec) begin
      remaining_mem[wr_addr_i] <= wr_remaining_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_arrival_o   <= arrival_mem[rd_addr_i];
    rd_burst_o     <= burst_mem[rd_addr_i];
    rd_remaining_o <= remaining_mem[rd_addr_i];
  end

endmodule

// ===== hw/rtl/srtf_preemptive_scheduler_top.sv =====
// Channel   Ports                      Handshake
// item      item_i (item_t)            taken when start is high and busy is low
// result    result_o (result_t)        valid for one cycle while done_o is high
//
// A load item gives its result on the next cycle, and the block can take another
// item in that same cycle. A tick item keeps busy high while it scans the table,
// then passes S_DECR when a process runs, S_TIME, then S_TAT, S_WAIT, S_SUMT and
// S_SUMW when that process completes, and S_OUT; its result
// follows in the next cycle. The serial scan reads one slot per cycle through the
// table's single read port. Reset clears all counters, time and totals; the table
// itself needs no clearing pass. The receiver cannot stall.
//
// Top level of the shortest-remaining-time-first scheduler.
// Depends on srtf_pkg, srtf_alu, srtf_mem and the assertion macro header.
`include "srtf_preemptive_scheduler_top_macros.svh"

module srtf_preemptive_scheduler_top import srtf_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);

  // Sequencer and bookkeeping registers.
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  entry_count_q, entry_count_d;
  logic [CNT_W-1:0]  completed_count_q, completed_count_d;
  logic [TIME_W-1:0] clock_time_q, clock_time_d;
  logic [SUM_W-1:0]  sum_tat_q, sum_tat_d;
  logic [SUM_W-1:0]  sum_wt_q, sum_wt_d;

  // Scan state: slot being read, slot whose data is back, best so far.
  logic [CNT_W-1:0]  issue_idx_q, issue_idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic [TIME_W-1:0] best_rt_q, best_rt_d;
  logic              fin_q, fin_d;
  logic [TIME_W-1:0] tat_q, tat_d;
  logic [TIME_W-1:0] wt_q, wt_d;

  logic              done_q, done_d;
  result_t           result_q, result_d;

  // Table interface.
  mem_wr_t           mem_wr;
  logic [IDX_W-1:0]  wr_addr;
  logic [TIME_W-1:0] wr_rem;
  logic [IDX_W-1:0]  rd_addr;
  logic [TIME_W-1:0] rd_arr, rd_bur, rd_rem;

  // Shared arithmetic unit.
  logic [SUM_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;

  logic              accept;
  logic              eligible;
  logic [CNT_W-1:0]  entry_inc;

  srtf_mem #(
    .DEPTH (MAX_PROCS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i          (clk_i),
    .wr_i           (mem_wr),
    .wr_addr_i      (wr_addr),
    .wr_arrival_i   (item_i.arrival_time),
    .wr_burst_i     (item_i.burst_time),
    .wr_remaining_i (wr_rem),
    .rd_addr_i      (rd_addr),
    .rd_arrival_o   (rd_arr),
    .rd_burst_o     (rd_bur),
    .rd_remaining_o (rd_rem)
  );

  srtf_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign entry_inc = entry_count_q + CNT_W'(1);

  // The shared unit serves a different purpose in each step of a tick.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_SCAN: begin
        // Remaining time of the candidate against the best so far.
        alu_a   = SUM_W'(rd_rem);
        alu_b   = SUM_W'(best_rt_q);
        alu_sub = 1'b1;
      end
      S_DECR: begin
        alu_a   = SUM_W'(best_rt_q);
        alu_b   = SUM_W'(1);
        alu_sub = 1'b1;
      end
      S_TIME: begin
        alu_a = SUM_W'(clock_time_q);
        alu_b = SUM_W'(1);
      end
      S_TAT: begin
        alu_a   = SUM_W'(clock_time_q);
        alu_b   = SUM_W'(rd_arr);
        alu_sub = 1'b1;
      end
      S_WAIT: begin
        alu_a   = SUM_W'(tat_q);
        alu_b   = SUM_W'(rd_bur);
        alu_sub = 1'b1;
      end
      S_SUMT: begin
        alu_a = sum_tat_q;
        alu_b = SUM_W'(tat_q);
      end
      S_SUMW: begin
        alu_a = sum_wt_q;
        alu_b = SUM_W'(wt_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // A slot is a candidate when it has work left, has arrived, and beats the
  // best so far strictly, so the lowest slot wins a tie.
  assign eligible = chk_vld_q && (rd_rem != '0) && (rd_arr <= clock_time_q) &&
                    (!found_q || !alu_carry);

  always_comb begin
    state_d           = state_q;
    entry_count_d     = entry_count_q;
    completed_count_d = completed_count_q;
    clock_time_d      = clock_time_q;
    sum_tat_d         = sum_tat_q;
    sum_wt_d          = sum_wt_q;
    issue_idx_d       = issue_idx_q;
    chk_vld_d         = 1'b0;
    chk_idx_d         = chk_idx_q;
    found_d           = found_q;
    best_d            = best_q;
    best_rt_d         = best_rt_q;
    fin_d             = fin_q;
    tat_d             = tat_q;
    wt_d              = wt_q;
    done_d            = 1'b0;
    result_d          = result_q;
    mem_wr            = '0;
    wr_addr           = best_q;
    wr_rem            = item_i.burst_time;
    rd_addr           = best_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.operation == OP_LOAD) begin
            done_d = 1'b1;
            result_d = '0;
            result_d.total_turnaround = sum_tat_q;
            result_d.total_waiting    = sum_wt_q;
            result_d.current_time     = clock_time_q;
            if (entry_count_q < CNT_FULL) begin
              mem_wr.load            = 1'b1;
              wr_addr                = entry_count_q[IDX_W-1:0];
              entry_count_d          = entry_inc;
              result_d.status        = ST_LOADED;
              result_d.process_index = PIDX_W'(entry_count_q);
              result_d.all_done      = (completed_count_q == entry_inc);
            end else begin
              result_d.status   = ST_FULL;
              result_d.all_done = (completed_count_q == entry_count_q);
            end
          end else begin
            issue_idx_d = '0;
            found_d     = 1'b0;
            fin_d       = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // One read issued per cycle; its data is checked on the next cycle.
        rd_addr = issue_idx_q[IDX_W-1:0];
        if (issue_idx_q < entry_count_q) begin
          issue_idx_d = issue_idx_q + CNT_W'(1);
          chk_vld_d   = 1'b1;
          chk_idx_d   = issue_idx_q[IDX_W-1:0];
        end
        if (eligible) begin
          found_d   = 1'b1;
          best_d    = chk_idx_q;
          best_rt_d = rd_rem;
        end
        if (!(issue_idx_q < entry_count_q) && !chk_vld_q) begin
          state_d = found_q ? S_DECR : S_TIME;
        end
      end

      S_DECR: begin
        // Run the chosen process for one unit; the read of its slot fetches
        // arrival and burst for the completion figures.
        mem_wr.dec = 1'b1;
        wr_rem     = alu_res[TIME_W-1:0];
        best_rt_d  = alu_res[TIME_W-1:0];
        fin_d      = (alu_res[TIME_W-1:0] == '0);
        if (alu_res[TIME_W-1:0] == '0) begin
          completed_count_d = completed_count_q + CNT_W'(1);
        end
        state_d = S_TIME;
      end

      S_TIME: begin
        clock_time_d = alu_res[TIME_W] ? TIME_MAX : alu_res[TIME_W-1:0];
        state_d      = fin_q ? S_TAT : S_OUT;
      end

      S_TAT: begin
        tat_d   = alu_carry ? alu_res[TIME_W-1:0] : '0;
        state_d = S_WAIT;
      end

      S_WAIT: begin
        wt_d    = alu_carry ? alu_res[TIME_W-1:0] : '0;
        state_d = S_SUMT;
      end

      S_SUMT: begin
        sum_tat_d = alu_carry ? SUM_MAX : alu_res;
        state_d   = S_SUMW;
      end

      S_SUMW: begin
        sum_wt_d = alu_carry ? SUM_MAX : alu_res;
        state_d  = S_OUT;
      end

      S_OUT: begin
        done_d                    = 1'b1;
        result_d                  = '0;
        result_d.total_turnaround = sum_tat_q;
        result_d.total_waiting    = sum_wt_q;
        result_d.all_done         = (completed_count_q == entry_count_q);
        result_d.current_time     = clock_time_q;
        if (found_q) begin
          result_d.status        = ST_RAN;
          result_d.process_index = PIDX_W'(best_q);
          if (fin_q) begin
            result_d.finished        = 1'b1;
            result_d.completion_time = clock_time_q;
            result_d.turnaround      = tat_q;
            result_d.waiting         = wt_q;
          end
        end else begin
          result_d.status = ST_IDLE;
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      entry_count_q     <= '0;
      completed_count_q <= '0;
      clock_time_q      <= '0;
      sum_tat_q         <= '0;
      sum_wt_q          <= '0;
      chk_vld_q         <= 1'b0;
      done_q            <= 1'b0;
    end else begin
      state_q           <= state_d;
      entry_count_q     <= entry_count_d;
      completed_count_q <= completed_count_d;
      clock_time_q      <= clock_time_d;
      sum_tat_q         <= sum_tat_d;
      sum_wt_q          <= sum_wt_d;
      chk_vld_q         <= chk_vld_d;
      done_q            <= done_d;
    end
  end

  // Working values of a tick and the result register carry no reset.
  always_ff @(posedge clk_i) begin
    issue_idx_q <= issue_idx_d;
    chk_idx_q   <= chk_idx_d;
    found_q     <= found_d;
    best_q      <= best_d;
    best_rt_q   <= best_rt_d;
    fin_q       <= fin_d;
    tat_q       <= tat_d;
    wt_q        <= wt_d;
    result_q    <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // No more processes can complete than were loaded.
  `SRTF_ASSERT(a_count_order, completed_count_q <= entry_count_q)
  // A load item always gives its result on the next cycle.
  `SRTF_ASSERT(a_load_result, accept && (item_i.operation == OP_LOAD) |=> done_o)
  // A result is only shown once the sequencer has returned to idle.
  `SRTF_ASSERT_NEVER(a_done_while_busy, done_o && busy)
  // Scheduler time never runs backward.
  `SRTF_ASSERT(a_time_monotonic, 1'b1 |=> clock_time_q >= $past(clock_time_q))

endmodule
